>>> rtl/core/ujac_pkg.sv
// Shared types, widths, constants and helper functions for the unicycle Jacobian unit.
`timescale 1ns / 1ps

package ujac_pkg;

  // Number of entries in the arctangent table.
  localparam int unsigned AtanTableLen = 24;
  localparam int unsigned CordicStagesDefault = 16;

  // Widths of the internal datapath.
  localparam int unsigned AngleW = 35;  // Q.30 angle before folding
  localparam int unsigned ZW     = 33;  // Q.30 residual angle inside the CORDIC
  localparam int unsigned XW     = 33;  // Q.30 CORDIC vector components
  localparam int unsigned TrigW  = 32;  // clamped Q.30 sine and cosine
  localparam int unsigned VdtW   = 33;  // speed times time step
  localparam int unsigned WideW  = 65;  // widest product

  localparam logic signed [AngleW-1:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [AngleW-1:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [AngleW-1:0] TwoPiQ30  = 35'sd6746518852;
  localparam logic signed [XW-1:0]     GainQ30   = 33'sd652032875;
  localparam logic signed [XW-1:0]     OneQ30    = 33'sd1073741824;

  localparam logic [15:0] TimeStepReset = 16'd655;

  // Operand set that travels alongside the rotating vector.
  typedef struct packed {
    logic               flip;
    logic signed [15:0] speed;
    logic signed [32:0] speed_dt;
    logic signed [15:0] turn_rate;
    logic signed [15:0] accel;
    logic [15:0]        time_step;
  } side_t;

  // Rounded Q.30 value of atan(2^-idx).
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:       r = 33'sd843314857;
      1:       r = 33'sd497837829;
      2:       r = 33'sd263043837;
      3:       r = 33'sd133525159;
      4:       r = 33'sd67021687;
      5:       r = 33'sd33543516;
      6:       r = 33'sd16775851;
      7:       r = 33'sd8388437;
      8:       r = 33'sd4194283;
      9:       r = 33'sd2097149;
      10:      r = 33'sd1048576;
      11:      r = 33'sd524288;
      12:      r = 33'sd262144;
      13:      r = 33'sd131072;
      14:      r = 33'sd65536;
      15:      r = 33'sd32768;
      16:      r = 33'sd16384;
      17:      r = 33'sd8192;
      18:      r = 33'sd4096;
      19:      r = 33'sd2048;
      20:      r = 33'sd1024;
      21:      r = 33'sd512;
      22:      r = 33'sd256;
      23:      r = 33'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 16 signed bits.
  function automatic logic signed [15:0] sat16(input logic signed [WideW-1:0] v);
    logic signed [15:0] r;
    if (v > 65'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -65'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Saturate a wide signed value to 17 signed bits.
  function automatic logic signed [16:0] sat17(input logic signed [WideW-1:0] v);
    logic signed [16:0] r;
    if (v > 65'sd65535) begin
      r = 17'sh0ffff;
    end else if (v < -65'sd65536) begin
      r = 17'sh10000;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ujac_range_reduce.sv
// Two-stage angle range reduction that also forms speed times time step.
`timescale 1ns / 1ps

module ujac_range_reduce (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [15:0]         heading_i,
  input  logic signed [15:0]         speed_i,
  input  logic signed [15:0]         turn_rate_i,
  input  logic signed [15:0]         accel_i,
  input  logic [15:0]                time_step_i,
  output logic                       valid_o,
  output logic signed [ujac_pkg::ZW-1:0] z_o,
  output ujac_pkg::side_t            side_o
);
  import ujac_pkg::*;

  logic                     valid1_q, valid2_q;
  logic signed [AngleW-1:0] z_in;
  logic signed [AngleW-1:0] z1_d, z1_q;
  logic signed [AngleW-1:0] z2_d;
  logic signed [ZW-1:0]     z2_q;
  side_t                    side1_d, side1_q, side2_d, side2_q;

  // Stage one: scale Q3.12 to Q.30 and wrap into [-pi, pi].
  assign z_in = {heading_i[15], heading_i, 18'b0};

  always_comb begin
    if (z_in > PiQ30) begin
      z1_d = z_in - TwoPiQ30;
    end else if (z_in < -PiQ30) begin
      z1_d = z_in + TwoPiQ30;
    end else begin
      z1_d = z_in;
    end
    side1_d           = '0;
    side1_d.speed     = speed_i;
    side1_d.speed_dt  = 33'(speed_i) * 33'($signed({1'b0, time_step_i}));
    side1_d.turn_rate = turn_rate_i;
    side1_d.accel     = accel_i;
    side1_d.time_step = time_step_i;
  end

  // Stage two: fold into [-pi/2, pi/2], remembering the sign flip.
  always_comb begin
    side2_d = side1_q;
    if (z1_q > HalfPiQ30) begin
      z2_d         = z1_q - PiQ30;
      side2_d.flip = 1'b1;
    end else if (z1_q < -HalfPiQ30) begin
      z2_d         = z1_q + PiQ30;
      side2_d.flip = 1'b1;
    end else begin
      z2_d         = z1_q;
      side2_d.flip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    z1_q    <= z1_d;
    side1_q <= side1_d;
    z2_q    <= z2_d[ZW-1:0];
    side2_q <= side2_d;
  end

  assign valid_o = valid2_q;
  assign z_o     = z2_q;
  assign side_o  = side2_q;

endmodule

>>> rtl/core/ujac_cordic_cell.sv
// One rotation-mode CORDIC cell with its own output register.
`timescale 1ns / 1ps

module ujac_cordic_cell #(
  parameter int unsigned                     Shift = 0,
  parameter logic signed [ujac_pkg::ZW-1:0]  Atan  = '0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [ujac_pkg::XW-1:0]     x_i,
  input  logic signed [ujac_pkg::XW-1:0]     y_i,
  input  logic signed [ujac_pkg::ZW-1:0]     z_i,
  input  ujac_pkg::side_t                    side_i,
  output logic                               valid_o,
  output logic signed [ujac_pkg::XW-1:0]     x_o,
  output logic signed [ujac_pkg::XW-1:0]     y_o,
  output logic signed [ujac_pkg::ZW-1:0]     z_o,
  output ujac_pkg::side_t                    side_o
);
  import ujac_pkg::*;

  logic                 valid_q;
  logic signed [XW-1:0] x_sh, y_sh, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  side_t                side_q;

  assign x_sh = x_i >>> Shift;
  assign y_sh = y_i >>> Shift;

  // Rotate toward zero residual angle.
  always_comb begin
    if (!z_i[ZW-1]) begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

>>> rtl/core/ujac_product.sv
// Sign correction, clamping, products, rounding and saturation of the results.
`timescale 1ns / 1ps

module ujac_product (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [ujac_pkg::XW-1:0] x_i,
  input  logic signed [ujac_pkg::XW-1:0] y_i,
  input  ujac_pkg::side_t                side_i,
  output logic                           done_o,
  output logic signed [15:0]             x_rate_o,
  output logic signed [15:0]             y_rate_o,
  output logic signed [15:0]             heading_rate_o,
  output logic signed [15:0]             speed_rate_o,
  output logic signed [15:0]             jx_heading_o,
  output logic signed [16:0]             jx_speed_o,
  output logic signed [15:0]             jy_heading_o,
  output logic signed [16:0]             jy_speed_o,
  output logic [15:0]                    control_gain_o
);
  import ujac_pkg::*;

  localparam logic signed [WideW-1:0] HalfQ30  = 65'sd536870912;
  localparam logic signed [WideW-1:0] HalfQ46  = 65'sd35184372088832;
  localparam logic signed [WideW-1:0] HalfQ46N = 65'sd35184372088833;

  logic                    valid1_q, valid2_q, done_q;
  logic signed [XW-1:0]    xf, yf;
  logic signed [TrigW-1:0] cos_d, sin_d, cos_q, sin_q;
  side_t                   side1_q, side2_q;

  logic signed [16:0]      dt_s;
  logic signed [47:0]      vc_d, vs_d, vc_q, vs_q;
  logic signed [48:0]      cdt_d, sdt_d, cdt_q, sdt_q;
  logic signed [WideW-1:0] vdtc_d, vdts_d, vdtc_q, vdts_q;

  logic signed [WideW-1:0] vc_r, vs_r, cdt_r, sdt_r, vdtc_r, nvdts_r;

  // Undo the half-turn fold, then clamp to [-1, 1].
  always_comb begin
    xf = side_i.flip ? -x_i : x_i;
    yf = side_i.flip ? -y_i : y_i;
    if (xf > OneQ30) begin
      cos_d = TrigW'(OneQ30);
    end else if (xf < -OneQ30) begin
      cos_d = TrigW'(-OneQ30);
    end else begin
      cos_d = xf[TrigW-1:0];
    end
    if (yf > OneQ30) begin
      sin_d = TrigW'(OneQ30);
    end else if (yf < -OneQ30) begin
      sin_d = TrigW'(-OneQ30);
    end else begin
      sin_d = yf[TrigW-1:0];
    end
  end

  // One multiplier per product.
  assign dt_s   = $signed({1'b0, side1_q.time_step});
  assign vc_d   = 48'(side1_q.speed) * 48'(cos_q);
  assign vs_d   = 48'(side1_q.speed) * 48'(sin_q);
  assign cdt_d  = 49'(cos_q) * 49'(dt_s);
  assign sdt_d  = 49'(sin_q) * 49'(dt_s);
  assign vdtc_d = 65'(side1_q.speed_dt) * 65'(cos_q);
  assign vdts_d = 65'(side1_q.speed_dt) * 65'(sin_q);

  // Round half up and drop the fraction. The negated term folds the
  // two's complement increment into the rounding constant.
  assign vc_r    = (65'(vc_q) + HalfQ30) >>> 30;
  assign vs_r    = (65'(vs_q) + HalfQ30) >>> 30;
  assign cdt_r   = (65'(cdt_q) + HalfQ30) >>> 30;
  assign sdt_r   = (65'(sdt_q) + HalfQ30) >>> 30;
  assign vdtc_r  = (vdtc_q + HalfQ46) >>> 46;
  assign nvdts_r = (~vdts_q + HalfQ46N) >>> 46;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      done_q   <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q          <= cos_d;
    sin_q          <= sin_d;
    side1_q        <= side_i;
    vc_q           <= vc_d;
    vs_q           <= vs_d;
    cdt_q          <= cdt_d;
    sdt_q          <= sdt_d;
    vdtc_q         <= vdtc_d;
    vdts_q         <= vdts_d;
    side2_q        <= side1_q;
    x_rate_o       <= sat16(vc_r);
    y_rate_o       <= sat16(vs_r);
    heading_rate_o <= side2_q.turn_rate;
    speed_rate_o   <= side2_q.accel;
    jx_heading_o   <= sat16(nvdts_r);
    jx_speed_o     <= sat17(cdt_r);
    jy_heading_o   <= sat16(vdtc_r);
    jy_speed_o     <= sat17(sdt_r);
    control_gain_o <= side2_q.time_step;
  end

  assign done_o = done_q;

endmodule

>>> rtl/core/unicycle_derivative_and_jacobian_unit.sv
// Top level of the unicycle state derivative and Jacobian increment unit.
`timescale 1ns / 1ps
// Pipeline: an accepted transaction passes the range reduction stages, the cell chain and
// the clamp, multiply and round stages, and then shows its result with done_o high.
// Throughput: one transaction per cycle; busy is always low, since every stage advances
// each cycle and the receiver cannot stall.
// Reset: rst_ni is asynchronous and active low; it empties the pipeline and sets the
// time step register to 655.

module unicycle_derivative_and_jacobian_unit #(
  parameter int unsigned CORDIC_STAGES = ujac_pkg::CordicStagesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               time_step_we_i,
  input  logic [15:0]        time_step_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] speed_i,
  input  logic signed [15:0] turn_rate_i,
  input  logic signed [15:0] accel_i,
  output logic               done_o,
  output logic signed [15:0] x_rate_o,
  output logic signed [15:0] y_rate_o,
  output logic signed [15:0] heading_rate_o,
  output logic signed [15:0] speed_rate_o,
  output logic signed [15:0] jx_heading_o,
  output logic signed [16:0] jx_speed_o,
  output logic signed [15:0] jy_heading_o,
  output logic signed [16:0] jy_speed_o,
  output logic [15:0]        control_gain_o
);
  import ujac_pkg::*;

  // Two range reduction stages, the cell chain, then clamp, multiply and round stages.
  localparam int unsigned Latency = CORDIC_STAGES + 5;

  logic                 accept;
  logic [15:0]          time_step_d, time_step_q;

  // Vector state at each point of the chain; entry i feeds cell i.
  logic                 chain_valid [CORDIC_STAGES+1];
  logic signed [XW-1:0] chain_x     [CORDIC_STAGES+1];
  logic signed [XW-1:0] chain_y     [CORDIC_STAGES+1];
  logic signed [ZW-1:0] chain_z     [CORDIC_STAGES+1];
  side_t                chain_side  [CORDIC_STAGES+1];

  // Every stage moves forward each cycle, so a new transaction is always taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // The time step register. Its value is captured with each transaction, so a
  // write only affects transactions accepted after it.
  always_comb begin
    time_step_d = time_step_q;
    if (time_step_we_i) begin
      time_step_d = time_step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TimeStepReset;
    end else begin
      time_step_q <= time_step_d;
    end
  end

  // Wrap and fold the heading, and form speed times time step for the
  // dt-scaled position Jacobian terms.
  ujac_range_reduce u_range_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .heading_i   (heading_i),
    .speed_i     (speed_i),
    .turn_rate_i (turn_rate_i),
    .accel_i     (accel_i),
    .time_step_i (time_step_q),
    .valid_o     (chain_valid[0]),
    .z_o         (chain_z[0]),
    .side_o      (chain_side[0])
  );

  // The CORDIC starts on the x axis at the inverse gain, so it ends on the unit circle.
  assign chain_x[0] = GainQ30;
  assign chain_y[0] = '0;

  // The chain of rotation cells. Cell i shifts by i and rotates by atan(2^-i);
  // each hands its vector and the operand set to the next one every cycle.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : gen_cell
    ujac_cordic_cell #(
      .Shift (i),
      .Atan  (atan_q30(i))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .x_i     (chain_x[i]),
      .y_i     (chain_y[i]),
      .z_i     (chain_z[i]),
      .side_i  (chain_side[i]),
      .valid_o (chain_valid[i+1]),
      .x_o     (chain_x[i+1]),
      .y_o     (chain_y[i+1]),
      .z_o     (chain_z[i+1]),
      .side_o  (chain_side[i+1])
    );
  end

  // Cosine and sine leave the chain as x and y. The final residual angle is
  // not needed.
  ujac_product u_product (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (chain_valid[CORDIC_STAGES]),
    .x_i            (chain_x[CORDIC_STAGES]),
    .y_i            (chain_y[CORDIC_STAGES]),
    .side_i         (chain_side[CORDIC_STAGES]),
    .done_o         (done_o),
    .x_rate_o       (x_rate_o),
    .y_rate_o       (y_rate_o),
    .heading_rate_o (heading_rate_o),
    .speed_rate_o   (speed_rate_o),
    .jx_heading_o   (jx_heading_o),
    .jx_speed_o     (jx_speed_o),
    .jy_heading_o   (jy_heading_o),
    .jy_speed_o     (jy_speed_o),
    .control_gain_o (control_gain_o)
  );

  // Every accepted transaction produces its result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted transaction did not produce a result on time");

  // A result only appears for a transaction accepted exactly one latency earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without a matching accepted transaction");

  // The pass-through fields stay aligned with their transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (heading_rate_o == $past(turn_rate_i, Latency)) &&
               (speed_rate_o == $past(accel_i, Latency)))
    else $error("pass-through fields out of step with the pipeline");

  // The control gain is the time step captured when the transaction was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> control_gain_o == $past(time_step_q, Latency))
    else $error("control gain does not match the captured time step");

endmodule

>>> sim/unicycle_kinematics_checker.sv
// Scoreboard that predicts and checks every result of the unicycle Jacobian unit.
`timescale 1ns / 1ps

module unicycle_kinematics_checker #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic               time_step_we_i,
  input  logic [15:0]        time_step_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] speed_i,
  input  logic signed [15:0] turn_rate_i,
  input  logic signed [15:0] accel_i,
  input  logic               done_i,
  input  logic signed [15:0] x_rate_i,
  input  logic signed [15:0] y_rate_i,
  input  logic signed [15:0] heading_rate_i,
  input  logic signed [15:0] speed_rate_i,
  input  logic signed [15:0] jx_heading_i,
  input  logic signed [16:0] jx_speed_i,
  input  logic signed [15:0] jy_heading_i,
  input  logic signed [16:0] jy_speed_i,
  input  logic [15:0]        control_gain_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);

  localparam longint PiQ30     = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint TwoPiQ30  = 64'sd6746518852;
  localparam longint GainQ30   = 64'sd652032875;
  localparam longint OneQ30    = 64'sd1073741824;
  localparam int     ArctanLen = 24;
  localparam logic [15:0] TimeStepAtReset = 16'd655;
  localparam int unsigned PrintCap = 40;

  typedef struct packed {
    logic signed [15:0] x_rate;
    logic signed [15:0] y_rate;
    logic signed [15:0] heading_rate;
    logic signed [15:0] speed_rate;
    logic signed [15:0] jx_heading;
    logic signed [16:0] jx_speed;
    logic signed [15:0] jy_heading;
    logic signed [16:0] jy_speed;
    logic [15:0]        control_gain;
  } kin_result_t;

  typedef struct packed {
    kin_result_t        res;
    logic [31:0]        seq;
    logic signed [15:0] heading;
    logic signed [15:0] speed;
    logic [15:0]        time_step;
  } kin_expect_t;

  // Q.30 rotation angles atan(2^-i), rounded to nearest.
  longint arctan_tab [0:ArctanLen-1] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048,
    1024, 512, 256, 128
  };

  kin_expect_t  expected_kin_q [$];
  logic [15:0]  time_step_q;
  int unsigned  sample_seq;

  // Round half up at bit sh, then clamp to [lo, hi].
  function automatic longint round_sat(input longint p, input int unsigned sh,
                                       input longint lo, input longint hi);
    longint q;
    q = (p + (longint'(1) <<< (sh - 1))) >>> sh;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q;
  endfunction

  function automatic kin_result_t unicycle_kinematics(
      input logic signed [15:0] theta, input logic signed [15:0] v_in,
      input logic signed [15:0] omega, input logic signed [15:0] acc,
      input logic [15:0] dt_in);
    longint      z;
    longint      x;
    longint      y;
    longint      x_next;
    longint      v;
    longint      dt;
    bit          flip;
    kin_result_t r;
    z    = longint'(theta) * 262144;
    x    = GainQ30;
    y    = 0;
    flip = 1'b0;
    v    = longint'(v_in);
    dt   = longint'(dt_in);
    // Wrap into [-pi, pi]; one turn is enough for the Q3.12 range, but the loop tries twice.
    repeat (2) begin
      if (z > PiQ30) z = z - TwoPiQ30;
      if (z < -PiQ30) z = z + TwoPiQ30;
    end
    // Fold into the right half plane and negate both outputs afterwards.
    if (z > HalfPiQ30) begin
      z    = z - PiQ30;
      flip = 1'b1;
    end else if (z < -HalfPiQ30) begin
      z    = z + PiQ30;
      flip = 1'b1;
    end
    for (int i = 0; i < int'(CORDIC_STAGES) && i < ArctanLen; i++) begin
      if (z >= 0) begin
        x_next = x - (y >>> i);
        y      = y + (x >>> i);
        z      = z - arctan_tab[i];
      end else begin
        x_next = x + (y >>> i);
        y      = y - (x >>> i);
        z      = z + arctan_tab[i];
      end
      x = x_next;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    if (x > OneQ30) x = OneQ30;
    if (x < -OneQ30) x = -OneQ30;
    if (y > OneQ30) y = OneQ30;
    if (y < -OneQ30) y = -OneQ30;
    r.x_rate       = 16'(round_sat(v * x, 30, -32768, 32767));
    r.y_rate       = 16'(round_sat(v * y, 30, -32768, 32767));
    r.heading_rate = omega;
    r.speed_rate   = acc;
    r.jx_heading   = 16'(round_sat(-(v * y * dt), 46, -32768, 32767));
    r.jx_speed     = 17'(round_sat(x * dt, 30, -65536, 65535));
    r.jy_heading   = 16'(round_sat(v * x * dt, 46, -32768, 32767));
    r.jy_speed     = 17'(round_sat(y * dt, 30, -65536, 65535));
    r.control_gain = dt_in;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PrintCap) $display("[%0t] MISMATCH %s", $time, msg);
    fail_count_o = fail_count_o + 1;
  endtask

  task automatic check_field(input string name, input kin_expect_t e,
                             input logic signed [63:0] got, input logic signed [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("#%0d %s: got %0d, expected %0d (heading %0d, speed %0d, dt %0d)",
                                e.seq, name, got, want, e.heading, e.speed, e.time_step));
    end
  endtask

  task automatic check_result();
    kin_expect_t e;
    if (expected_kin_q.size() == 0) begin
      report_mismatch($sformatf("result with no transaction outstanding (x_rate %0d)",
                                x_rate_i));
    end else begin
      e         = expected_kin_q.pop_front();
      checked_o = checked_o + 1;
      check_field("x_rate", e, x_rate_i, e.res.x_rate);
      check_field("y_rate", e, y_rate_i, e.res.y_rate);
      check_field("heading_rate", e, heading_rate_i, e.res.heading_rate);
      check_field("speed_rate", e, speed_rate_i, e.res.speed_rate);
      check_field("jx_heading", e, jx_heading_i, e.res.jx_heading);
      check_field("jx_speed", e, jx_speed_i, e.res.jx_speed);
      check_field("jy_heading", e, jy_heading_i, e.res.jy_heading);
      check_field("jy_speed", e, jy_speed_i, e.res.jy_speed);
      check_field("control_gain", e, control_gain_i, e.res.control_gain);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kin_expect_t e;
    if (!rst_ni) begin
      time_step_q = TimeStepAtReset;
      expected_kin_q.delete();
      sample_seq   = 0;
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // Check before queuing, so a result never matches a transaction of the same edge.
      if (done_i) check_result();
      if (start && !busy) begin
        e.res       = unicycle_kinematics(heading_i, speed_i, turn_rate_i, accel_i,
                                          time_step_q);
        e.seq       = sample_seq;
        e.heading   = heading_i;
        e.speed     = speed_i;
        e.time_step = time_step_q;
        expected_kin_q.push_back(e);
        sample_seq  = sample_seq + 1;
      end
      if (time_step_we_i) time_step_q = time_step_i;
      pending_o = expected_kin_q.size();
    end
  end

endmodule

>>> sim/unicycle_derivative_and_jacobian_unit_test.sv
// Top of the unicycle Jacobian unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The stimulus side feeds heading, speed and control samples into the block and
// changes the time step register between phases, while the checker beside the
// block predicts every result and compares it field by field. This module only
// makes stimulus, guards against hangs and prints the verdict.
module unicycle_derivative_and_jacobian_unit_test;

  localparam int unsigned Stages = 16;
  localparam int unsigned Latency = Stages + 5;
  // The longest quiet stretch of a correct run is the longest sender gap plus the
  // pipeline latency plus a register write. The limit is many times that, yet
  // still stops a hung run quickly.
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned PhaseItems = 280;
  localparam int unsigned PhaseCount = 6;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               time_step_we_i = 1'b0;
  logic [15:0]        time_step_i    = '0;
  logic signed [15:0] heading_i      = '0;
  logic signed [15:0] speed_i        = '0;
  logic signed [15:0] turn_rate_i    = '0;
  logic signed [15:0] accel_i        = '0;
  logic               busy;
  logic               done_o;
  logic signed [15:0] x_rate_o;
  logic signed [15:0] y_rate_o;
  logic signed [15:0] heading_rate_o;
  logic signed [15:0] speed_rate_o;
  logic signed [15:0] jx_heading_o;
  logic signed [16:0] jx_speed_o;
  logic signed [15:0] jy_heading_o;
  logic signed [16:0] jy_speed_o;
  logic [15:0]        control_gain_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned samples_sent   = 0;
  int unsigned setting_writes = 0;
  int unsigned idle_cycles    = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  unicycle_derivative_and_jacobian_unit #(
    .CORDIC_STAGES(Stages)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .time_step_we_i (time_step_we_i),
    .time_step_i    (time_step_i),
    .heading_i      (heading_i),
    .speed_i        (speed_i),
    .turn_rate_i    (turn_rate_i),
    .accel_i        (accel_i),
    .done_o         (done_o),
    .x_rate_o       (x_rate_o),
    .y_rate_o       (y_rate_o),
    .heading_rate_o (heading_rate_o),
    .speed_rate_o   (speed_rate_o),
    .jx_heading_o   (jx_heading_o),
    .jx_speed_o     (jx_speed_o),
    .jy_heading_o   (jy_heading_o),
    .jy_speed_o     (jy_speed_o),
    .control_gain_o (control_gain_o)
  );

  unicycle_kinematics_checker #(
    .CORDIC_STAGES(Stages)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .time_step_we_i (time_step_we_i),
    .time_step_i    (time_step_i),
    .heading_i      (heading_i),
    .speed_i        (speed_i),
    .turn_rate_i    (turn_rate_i),
    .accel_i        (accel_i),
    .done_i         (done_o),
    .x_rate_i       (x_rate_o),
    .y_rate_i       (y_rate_o),
    .heading_rate_i (heading_rate_o),
    .speed_rate_i   (speed_rate_o),
    .jx_heading_i   (jx_heading_o),
    .jx_speed_i     (jx_speed_o),
    .jy_heading_i   (jy_heading_o),
    .jy_speed_i     (jy_speed_o),
    .control_gain_i (control_gain_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count),
    .checked_o      (checked_count)
  );

  // The watchdog restarts on every accepted transaction and every result. If the
  // block stops taking samples or a result never arrives, it ends the run.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               IdleLimit, pending_count);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Angles where the range reduction changes branch: zero, plus and minus pi/2,
  // plus and minus pi, plus and minus 2*pi, and both ends of the Q3.12 range.
  function automatic logic signed [15:0] special_heading(input int unsigned idx);
    logic signed [15:0] h;
    case (idx)
      0:       h = 16'sd0;
      1:       h = 16'sd6434;
      2:       h = -16'sd6434;
      3:       h = 16'sd12868;
      4:       h = -16'sd12868;
      5:       h = 16'sd25736;
      6:       h = 16'sd32767;
      7:       h = -16'sd32768;
      default: h = -16'sd25736;
    endcase
    return h;
  endfunction

  function automatic logic signed [15:0] extreme_speed(input int unsigned idx);
    logic signed [15:0] v;
    case (idx)
      0:       v = -16'sd32768;
      1:       v = 16'sd32767;
      2:       v = 16'sd0;
      3:       v = 16'sd1;
      default: v = -16'sd1;
    endcase
    return v;
  endfunction

  // Half of the headings span the whole input range, which exercises the wrap;
  // the rest sit inside one turn or just around a branch point.
  function automatic logic signed [15:0] pick_heading();
    int unsigned sel;
    int          h;
    sel = $urandom_range(0, 3);
    if (sel < 2) begin
      h = $urandom;
    end else if (sel == 2) begin
      h = $urandom_range(0, 25736) - 12868;
    end else begin
      h = special_heading($urandom_range(0, 8)) + $urandom_range(0, 4) - 2;
    end
    return 16'(h);
  endfunction

  function automatic logic signed [15:0] pick_speed();
    logic signed [15:0] v;
    if ($urandom_range(0, 7) == 0) begin
      v = extreme_speed($urandom_range(0, 4));
    end else begin
      v = 16'($urandom);
    end
    return v;
  endfunction

  // Lower start and wait until every accepted transaction has produced its
  // result. The pending count is sampled at the falling edge, where it is stable.
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // The time step register is only written with the pipeline empty. Every sample
  // produces a result, so an empty scoreboard means an empty pipeline.
  task automatic write_time_step(input logic [15:0] value);
    wait_idle();
    time_step_we_i <= 1'b1;
    time_step_i    <= value;
    @(posedge clk_i);
    time_step_we_i <= 1'b0;
    setting_writes++;
  endtask

  // Offer one sample after an idle gap and return at the edge that accepts it.
  // During the gap the fields carry junk that the block has to ignore. With no
  // gap, start simply stays high from the previous transaction.
  task automatic send_sample(input logic signed [15:0] heading, input logic signed [15:0] speed,
                             input logic signed [15:0] turn_rate, input logic signed [15:0] accel,
                             input int unsigned gap);
    if (gap > 0) begin
      start       <= 1'b0;
      heading_i   <= 16'($urandom);
      speed_i     <= 16'($urandom);
      turn_rate_i <= 16'($urandom);
      accel_i     <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    heading_i   <= heading;
    speed_i     <= speed;
    turn_rate_i <= turn_rate;
    accel_i     <= accel;
    // Busy only changes at a rising edge, so a low value seen at the falling edge
    // holds through the next rising edge, which then accepts the transaction.
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    samples_sent++;
  endtask

  // Branch-point headings against extreme speeds, with the turn rate at its limits
  // and the acceleration at its limits or zero. With the time step at its maximum this reaches the
  // saturation of the dt-scaled speed terms.
  task automatic run_directed();
    logic signed [15:0] turn_rate;
    logic signed [15:0] accel;
    for (int k = 0; k < 24; k++) begin
      turn_rate = k[0] ? -16'sd32768 : 16'sd32767;
      if (k % 3 == 0) begin
        accel = 16'sd0;
      end else begin
        accel = k[1] ? 16'sd32767 : -16'sd32768;
      end
      send_sample(special_heading(k % 8), extreme_speed(k / 8), turn_rate, accel, 0);
    end
  endtask

  // Random samples in runs of 32. A third of the runs go back to back; in the others
  // each sample waits a random idle gap, so gaps land on every stage.
  task automatic run_random(input int unsigned count);
    bit          back_to_back;
    int unsigned gap;
    back_to_back = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 32 == 0) back_to_back = ($urandom_range(0, 2) == 0);
      gap = back_to_back ? 0 : $urandom_range(0, 7);
      send_sample(pick_heading(), pick_speed(), 16'($urandom), 16'($urandom), gap);
    end
  endtask

  initial begin
    logic [15:0] dt_value;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A short batch relies on the time step left by reset.
    run_random(24);

    // Largest time step for the directed corners, then random samples under it.
    write_time_step(16'hffff);
    run_directed();
    run_random(PhaseItems);

    // Remaining settings: the reset value written back, zero (which must clear
    // every dt-scaled output), one, the top bit alone, and random values.
    for (int p = 0; p < int'(PhaseCount); p++) begin
      case (p)
        0:       dt_value = 16'd655;
        1:       dt_value = 16'd0;
        2:       dt_value = 16'd1;
        3:       dt_value = 16'h8000;
        default: dt_value = 16'($urandom_range(1, 65535));
      endcase
      write_time_step(dt_value);
      run_random(PhaseItems);
    end

    // Drain the pipeline, then give a stray extra result time to show up.
    wait_idle();
    repeat (Latency + 8) @(posedge clk_i);

    $display("Summary: %0d samples accepted, %0d results checked, %0d time step writes",
             samples_sent, checked_count, setting_writes);
    $display("Covered wrapped and folded headings, speed and control extremes, dt 0/1/655/max.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ujac_pkg.sv
rtl/core/ujac_range_reduce.sv
rtl/core/ujac_cordic_cell.sv
rtl/core/ujac_product.sv
rtl/core/unicycle_derivative_and_jacobian_unit.sv
sim/unicycle_kinematics_checker.sv
sim/unicycle_derivative_and_jacobian_unit_test.sv
